[hw/rtl/rrq_pkg.sv]
package rrq_pkg;

    localparam int RRQ_DEPTH     = 16;
    localparam int RRQ_TASK_BITS = 32;
    localparam int CAP_W         = 5;
    localparam int ACTION_W      = 3;
    localparam int SLOT_W        = 4;
    localparam int TOKEN_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int OCC_W         = 5;
    localparam int CAP_RESET     = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RESERVE = 3'd0,
        ACT_COMMIT  = 3'd1,
        ACT_CANCEL  = 3'd2,
        ACT_TAKE    = 3'd3,
        ACT_STOP    = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_UNAVAILABLE = 3'd1,
        ST_FULL        = 3'd2,
        ST_NOT_READY   = 3'd3,
        ST_DRAINED     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_EMPTY    = 2'd0,
        MODE_RESERVED = 2'd1,
        MODE_READY    = 2'd2,
        MODE_CANCELED = 2'd3
    } t_mode;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic                task_valid;
        logic [TOKEN_W-1:0]  task_token;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [TOKEN_W-1:0]  task_out;
        logic [OCC_W-1:0]    occupancy;
    } t_out_item;

    typedef logic [CAP_W-1:0] t_cap;

    function automatic int f_idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[hw/rtl/rrq_chan_if.sv]
interface rrq_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/rrq_ram.sv]
module rrq_ram
    import rrq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = RRQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [f_idx_bits(DEPTH)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]              i_wr_data,
    input  logic [f_idx_bits(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]              o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[hw/rtl/reservation_ring_queue.sv]
// Reservation ring queue: a ring of slots that are reserved at the tail, committed with a task
// token or canceled in any order, and handed out strictly in order from the head. Each
// transaction on the input channel yields exactly one result transaction unless a capacity write
// arrives while it is in progress. A reserve, commit or cancel passes through the dispatch, execute
// and done states and accepts the next transaction only after its result is presented; a reserve
// refused for stopping or a full ring, a commit or cancel naming a slot outside the capacity, and
// an unknown action go from dispatch straight to done. A cancel or a commit that cancels then walks
// the retirement from the head, and a take walks it over canceled head slots; a take that finds the
// ring empty ends its walk at once. Retirement reads and rewrites the slot-mode memory one entry at
// a time. A stop visits every slot within the capacity, canceling each reserved one, then runs the
// retirement walk. A result that waits at the output holds the block until it is taken. After reset
// and after every capacity write, the slot-mode memory is cleared entry by entry, during which no
// input transaction is accepted. A capacity of zero behaves as one and a capacity above DEPTH
// behaves as DEPTH; writing the capacity empties the ring but keeps the stopping state.
module reservation_ring_queue
    import rrq_pkg::*;
#(
    parameter int DEPTH     = RRQ_DEPTH,
    parameter int TASK_BITS = RRQ_TASK_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrq_chan_if.sink   i_in,
    rrq_chan_if.source o_out,
    rrq_chan_if.sink   i_cfg
);
    localparam int IDX_W = f_idx_bits(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DISPATCH = 9'b000000100,
        S_EXEC     = 9'b000001000,
        S_STOP_RD  = 9'b000010000,
        S_STOP_CHK = 9'b000100000,
        S_RET_RD   = 9'b001000000,
        S_RET_CHK  = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    t_in_item              r_item, n_item;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_held, n_held;
    logic                  r_stop, n_stop;
    t_cap                  r_cap, n_cap;
    t_status               r_status, n_status;
    logic [SLOT_W-1:0]     r_slot_out, n_slot_out;
    logic [TOKEN_W-1:0]    r_task_out, n_task_out;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic [CNT_W-1:0]      eff_cap;
    logic [CNT_W:0]        tail_sum;
    logic [IDX_W-1:0]      tail;
    logic [CNT_W-1:0]      head_inc;
    logic [IDX_W-1:0]      head_next;
    logic [CNT_W-1:0]      idx_inc;
    logic                  slot_ok;
    logic                  in_fire;
    logic                  cfg_fire;

    logic                  mode_we;
    logic [IDX_W-1:0]      mode_waddr;
    t_mode                 mode_wdata;
    logic [IDX_W-1:0]      rd_addr;
    logic [1:0]            mode_rd;
    t_mode                 mode_q;
    logic                  task_we;
    logic [TASK_BITS-1:0]  task_wdata;
    logic [TASK_BITS-1:0]  task_rd;

    rrq_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_mode_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mode_we),
        .i_wr_addr (mode_waddr),
        .i_wr_data (mode_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (mode_rd)
    );

    rrq_ram #(
        .WIDTH (TASK_BITS),
        .DEPTH (DEPTH)
    ) u_task_ram (
        .i_clk     (i_clk),
        .i_wr_en   (task_we),
        .i_wr_addr (r_idx),
        .i_wr_data (task_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (task_rd)
    );

    assign mode_q     = t_mode'(mode_rd);
    assign task_wdata = TASK_BITS'(r_item.task_token);

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(r_cap) > DEPTH) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    always_comb begin
        tail_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_held);
        if (tail_sum >= (CNT_W+1)'(eff_cap)) begin
            tail = IDX_W'(tail_sum - (CNT_W+1)'(eff_cap));
        end else begin
            tail = IDX_W'(tail_sum);
        end
        head_inc  = CNT_W'(r_head) + CNT_W'(1);
        head_next = (head_inc >= eff_cap) ? '0 : IDX_W'(head_inc);
        idx_inc   = CNT_W'(r_idx) + CNT_W'(1);
        slot_ok   = 32'(r_item.slot) < 32'(eff_cap);
    end

    assign cfg_fire    = i_cfg.valid;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_head      = r_head;
        n_held      = r_held;
        n_stop      = r_stop;
        n_cap       = r_cap;
        n_status    = r_status;
        n_slot_out  = r_slot_out;
        n_task_out  = r_task_out;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        mode_we     = 1'b0;
        mode_waddr  = r_idx;
        mode_wdata  = MODE_EMPTY;
        task_we     = 1'b0;
        rd_addr     = r_head;

        unique case (r_state)
            S_CLEAR: begin
                mode_we = 1'b1;
                if (r_idx == IDX_W'(DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_item  = i_in.payload;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status   = ST_UNAVAILABLE;
                n_slot_out = '0;
                n_task_out = '0;
                n_state    = S_DONE;
                unique case (r_item.action)
                    ACT_RESERVE: begin
                        rd_addr = tail;
                        n_idx   = tail;
                        if (r_stop) begin
                            n_status = ST_UNAVAILABLE;
                        end else if (r_held >= eff_cap) begin
                            n_status = ST_FULL;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                    ACT_COMMIT, ACT_CANCEL: begin
                        rd_addr = IDX_W'(r_item.slot);
                        n_idx   = IDX_W'(r_item.slot);
                        if (slot_ok) begin
                            n_state = S_EXEC;
                        end
                    end
                    ACT_TAKE: begin
                        n_state = S_RET_RD;
                    end
                    ACT_STOP: begin
                        n_stop   = 1'b1;
                        n_status = ST_OK;
                        n_idx    = '0;
                        n_state  = S_STOP_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (r_item.action == ACT_RESERVE) begin
                    if (mode_q == MODE_EMPTY) begin
                        mode_we    = 1'b1;
                        mode_wdata = MODE_RESERVED;
                        n_held     = r_held + CNT_W'(1);
                        n_slot_out = SLOT_W'(r_idx);
                        n_status   = ST_OK;
                    end
                end else if (mode_q == MODE_RESERVED) begin
                    if (r_item.action == ACT_COMMIT && !r_stop && r_item.task_valid) begin
                        mode_we    = 1'b1;
                        mode_wdata = MODE_READY;
                        task_we    = 1'b1;
                        n_status   = ST_OK;
                    end else begin
                        mode_we    = 1'b1;
                        mode_wdata = MODE_CANCELED;
                        if (r_item.action == ACT_CANCEL) begin
                            n_status = ST_OK;
                        end
                        n_state = S_RET_RD;
                    end
                end
            end
            S_STOP_RD: begin
                rd_addr = r_idx;
                n_state = S_STOP_CHK;
            end
            S_STOP_CHK: begin
                if (mode_q == MODE_RESERVED) begin
                    mode_we    = 1'b1;
                    mode_wdata = MODE_CANCELED;
                end
                if (idx_inc >= eff_cap) begin
                    n_state = S_RET_RD;
                end else begin
                    n_idx   = IDX_W'(idx_inc);
                    n_state = S_STOP_RD;
                end
            end
            S_RET_RD: begin
                rd_addr = r_head;
                if (r_held == '0) begin
                    if (r_item.action == ACT_TAKE) begin
                        n_status = r_stop ? ST_DRAINED : ST_NOT_READY;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_RET_CHK;
                end
            end
            S_RET_CHK: begin
                mode_waddr = r_head;
                if (mode_q == MODE_CANCELED) begin
                    mode_we    = 1'b1;
                    mode_wdata = MODE_EMPTY;
                    n_head     = head_next;
                    n_held     = r_held - CNT_W'(1);
                    n_state    = S_RET_RD;
                end else begin
                    n_state = S_DONE;
                    if (r_item.action == ACT_TAKE) begin
                        if (mode_q == MODE_READY) begin
                            mode_we    = 1'b1;
                            mode_wdata = MODE_EMPTY;
                            n_head     = head_next;
                            n_held     = r_held - CNT_W'(1);
                            n_task_out = TOKEN_W'(task_rd);
                            n_status   = ST_OK;
                        end else begin
                            n_status = ST_NOT_READY;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.slot_out  = r_slot_out;
                    n_out.task_out  = r_task_out;
                    n_out.occupancy = OCC_W'(r_held);
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase

        if (cfg_fire) begin
            n_cap   = i_cfg.payload;
            n_head  = '0;
            n_held  = '0;
            n_idx   = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_head      <= '0;
            r_held      <= '0;
            r_stop      <= 1'b0;
            r_cap       <= CAP_W'(CAP_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_head      <= n_head;
            r_held      <= n_held;
            r_stop      <= n_stop;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        r_task_out <= n_task_out;
        r_out      <= n_out;
    end

`ifndef SYNTHESIS
    a_held_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= eff_cap)
        else $error("held count exceeds the ring capacity");

    a_head_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_head) < eff_cap)
        else $error("head index outside the ring");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result presented without a finished transaction");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_DISPATCH) || (r_state == S_CLEAR))
        else $error("input transaction accepted outside the idle state");
`endif
endmodule
